// ===== sv/gb3x3_pkg.sv =====
// Shared types and constants of the 3x3 Gaussian blur.
package gb3x3_pkg;

  localparam int CHAN_W = 8;
  localparam int NUM_CHAN = 3;
  localparam int PIX_W = CHAN_W * NUM_CHAN;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE = 2'd2;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  // Control shared by every window column cell.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // Where the rows of a new window column come from.
  typedef enum logic [1:0] {
    SRC_FIRST_ROW,
    SRC_SECOND_ROW,
    SRC_BODY,
    SRC_DRAIN
  } col_src_t;

  // One channel of a 3x3 neighborhood, indexed [column][row].
  typedef logic [2:0][2:0][CHAN_W-1:0] win_t;

endpackage

// ===== sv/gb3x3_col_cell.sv =====
// One column cell of the window chain: three pixels handed on to the older neighbor.
module gb3x3_col_cell (
  input  logic                clk,
  input  logic                rst,
  input  gb3x3_pkg::cell_ctl_t ctl,
  input  gb3x3_pkg::column_t  d,
  output gb3x3_pkg::column_t  q
);
  import gb3x3_pkg::*;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      q <= '0;
    end else if (ctl.shift) begin
      q <= d;
    end
  end

endmodule

// ===== sv/gb3x3_kernel.sv =====
// One channel of the 1 2 1 / 2 4 2 / 1 2 1 kernel, divided by 16.
module gb3x3_kernel (
  input  gb3x3_pkg::win_t              win,
  output logic [gb3x3_pkg::CHAN_W-1:0] result
);
  import gb3x3_pkg::*;

  logic [CHAN_W+1:0] col_sum [3];
  logic [CHAN_W+3:0] total;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      col_sum[c] = {2'b00, win[c][0]} + {1'b0, win[c][1], 1'b0} + {2'b00, win[c][2]};
    end
    total = {2'b00, col_sum[0]} + {1'b0, col_sum[1], 1'b0} + {2'b00, col_sum[2]};
    result = total[CHAN_W+3:4];
  end

endmodule

// ===== sv/gb3x3_line_store.sv =====
// The two line stores: the line above the previous one and the previous line.
module gb3x3_line_store #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output gb3x3_pkg::pixel_t        rd_upper,
  output gb3x3_pkg::pixel_t        rd_middle,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic                     wr_upper_en,
  input  gb3x3_pkg::pixel_t        wr_upper_data,
  input  logic                     wr_middle_en,
  input  gb3x3_pkg::pixel_t        wr_middle_data
);
  import gb3x3_pkg::*;

  pixel_t upper_mem [DEPTH];
  pixel_t middle_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_upper_en) begin
      upper_mem[wr_addr] <= wr_upper_data;
    end
    if (rd_en) begin
      rd_upper <= upper_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_middle_en) begin
      middle_mem[wr_addr] <= wr_middle_data;
    end
    if (rd_en) begin
      rd_middle <= middle_mem[rd_addr];
    end
  end

endmodule

// ===== sv/gaussian_blur_3x3.sv =====
// Top level of the streaming 3x3 Gaussian blur with edge replication.
//
// Pixels of one frame enter in raster order, one word per clock, and each
// channel is filtered with 1 2 1 / 2 4 2 / 1 2 1 over 16, rounded down. A
// result word passes the decode, kernel and output registers; the
// pipeline (line store read, window column cells, kernel adders) takes one
// word every cycle and stalls as a whole only while the output register is
// full and not taken. The result for a pixel is released one line and one
// pixel later, so after the last pixel frame_width+1 drain words (tuser set)
// flush the rest; m_tlast marks the last result. Drain words sent before the
// last pixel are dropped, and pixel words sent during the drain count as
// drain words. Any write to a known register restarts the frame. Widths and
// heights below 3 act as 3, above the maximum as the maximum. The line stores
// need no clearing pass after reset.
module gaussian_blur_3x3 #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  // s_tdata: chan_zero[7:0], chan_one[15:8], chan_two[23:16]
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [gb3x3_pkg::PIX_W-1:0]         s_tdata,
  // s_tuser: kind[0]
  input  logic                                s_tuser,
  // m_tdata: out_zero[7:0], out_one[15:8], out_two[23:16]; frame_end on m_tlast
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [gb3x3_pkg::PIX_W-1:0]         m_tdata,
  output logic                                m_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gb3x3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gb3x3_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import gb3x3_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic [WW-1:0] WIDTH_MAX = WW'(MAX_WIDTH);
  localparam logic [HW-1:0] HEIGHT_MAX = HW'(MAX_HEIGHT);

  typedef struct packed {
    logic          valid;
    logic          emit;
    logic          post;
    logic          x_one;
    logic          push;
    logic          clear;
    logic          last;
    logic          wr_upper;
    logic          wr_middle;
    col_src_t      src;
    logic [AW-1:0] addr;
    pixel_t        pix;
  } stage_t;

  logic [WW-1:0] width_eff;
  logic [HW-1:0] height_eff;
  logic          color_mode;
  logic [WW-1:0] column_count;
  logic [HW-1:0] row_count;
  logic [WW-1:0] column_count_next;
  logic [HW-1:0] row_count_next;
  logic [WW-1:0] width_clamp;
  logic [HW-1:0] height_clamp;

  logic      adv;
  logic      in_accept;
  logic      cfg_restart;
  logic      drain;
  stage_t    s1;
  stage_t    s1_next;
  pixel_t    rd_upper;
  pixel_t    rd_middle;
  column_t   new_col;
  column_t   cell_q [3];
  cell_ctl_t cell_ctl;
  logic      s2_fire;

  logic               k_valid;
  logic               k_last;
  column_t [2:0]      k_col;
  win_t               k_win [NUM_CHAN];
  logic [CHAN_W-1:0]  k_res [NUM_CHAN];

  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign cfg_ready = 1'b1;
  assign in_accept = s_tvalid && s_tready;
  assign cfg_restart = cfg_valid && cfg_ready &&
                       (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT ||
                        cfg_index == CFG_COLOR_MODE);
  assign drain = row_count >= height_eff;

  // Size limits applied when a register is written.
  always_comb begin
    if (cfg_data < CFG_DATA_W'(3)) begin
      width_clamp = WW'(3);
      height_clamp = HW'(3);
    end else begin
      width_clamp = (32'(cfg_data) > MAX_WIDTH) ? WIDTH_MAX : WW'(cfg_data);
      height_clamp = (32'(cfg_data) > MAX_HEIGHT) ? HEIGHT_MAX : HW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff <= WW'(3);
      height_eff <= HW'(3);
      color_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  width_eff <= width_clamp;
        CFG_FRAME_HEIGHT: height_eff <= height_clamp;
        CFG_COLOR_MODE:   color_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Decode of the accepted word and the position counters.
  always_comb begin
    s1_next = '0;
    column_count_next = column_count;
    row_count_next = row_count;
    s1_next.addr = column_count[AW-1:0];
    s1_next.pix = {color_mode ? s_tdata[PIX_W-1:CHAN_W] : '0, s_tdata[CHAN_W-1:0]};
    s1_next.x_one = column_count == WW'(1);
    s1_next.src = SRC_DRAIN;
    if (drain) begin
      s1_next.valid = 1'b1;
      s1_next.emit = 1'b1;
      if (column_count == '0) begin
        s1_next.push = 1'b1;
        column_count_next = WW'(1);
      end else if (column_count < width_eff) begin
        s1_next.push = 1'b1;
        s1_next.post = 1'b1;
        column_count_next = column_count + WW'(1);
      end else begin
        // End of the drain: last result of the frame, then a fresh frame.
        s1_next.clear = 1'b1;
        s1_next.last = 1'b1;
        column_count_next = '0;
        row_count_next = '0;
      end
    end else if (!s_tuser) begin
      s1_next.valid = 1'b1;
      s1_next.push = 1'b1;
      s1_next.post = column_count != '0;
      s1_next.emit = (column_count == '0) ? (row_count >= HW'(2)) : (row_count != '0);
      s1_next.wr_middle = 1'b1;
      s1_next.wr_upper = row_count != '0;
      if (row_count == '0) begin
        s1_next.src = SRC_FIRST_ROW;
      end else if (row_count == HW'(1)) begin
        s1_next.src = SRC_SECOND_ROW;
      end else begin
        s1_next.src = SRC_BODY;
      end
      if (column_count == width_eff - WW'(1)) begin
        column_count_next = '0;
        row_count_next = row_count + HW'(1);
      end else begin
        column_count_next = column_count + WW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      column_count <= '0;
      row_count <= '0;
    end else if (in_accept) begin
      column_count <= column_count_next;
      row_count <= row_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (adv) begin
      s1.valid <= in_accept && s1_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1.emit <= s1_next.emit;
      s1.post <= s1_next.post;
      s1.x_one <= s1_next.x_one;
      s1.push <= s1_next.push;
      s1.clear <= s1_next.clear;
      s1.last <= s1_next.last;
      s1.wr_upper <= s1_next.wr_upper;
      s1.wr_middle <= s1_next.wr_middle;
      s1.src <= s1_next.src;
      s1.addr <= s1_next.addr;
      s1.pix <= s1_next.pix;
    end
  end

  assign s2_fire = adv && s1.valid;

  gb3x3_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk            (clk),
    .rd_en          (adv),
    .rd_addr        (column_count[AW-1:0]),
    .rd_upper       (rd_upper),
    .rd_middle      (rd_middle),
    .wr_addr        (s1.addr),
    .wr_upper_en    (s2_fire && s1.wr_upper),
    .wr_upper_data  (rd_middle),
    .wr_middle_en   (s2_fire && s1.wr_middle),
    .wr_middle_data (s1.pix)
  );

  always_comb begin
    case (s1.src)
      SRC_FIRST_ROW:  new_col = '{top: s1.pix, mid: s1.pix, bot: s1.pix};
      SRC_SECOND_ROW: new_col = '{top: rd_middle, mid: rd_middle, bot: s1.pix};
      SRC_BODY:       new_col = '{top: rd_upper, mid: rd_middle, bot: s1.pix};
      SRC_DRAIN:      new_col = '{top: rd_upper, mid: rd_middle, bot: rd_middle};
      default:        new_col = '{top: rd_upper, mid: rd_middle, bot: s1.pix};
    endcase
  end

  assign cell_ctl.shift = s2_fire && s1.push;
  assign cell_ctl.clear = cfg_restart || (s2_fire && s1.clear);

  // Window chain: cell 2 takes the new column, cell 0 holds the oldest.
  gb3x3_col_cell u_cell0 (.clk(clk), .rst(rst), .ctl(cell_ctl), .d(cell_q[1]), .q(cell_q[0]));
  gb3x3_col_cell u_cell1 (.clk(clk), .rst(rst), .ctl(cell_ctl), .d(cell_q[2]), .q(cell_q[1]));
  gb3x3_col_cell u_cell2 (.clk(clk), .rst(rst), .ctl(cell_ctl), .d(new_col), .q(cell_q[2]));

  // The kernel columns are taken from the window before the push; a result
  // that follows the push sees the window one column further on.
  always_ff @(posedge clk) begin
    if (rst) begin
      k_valid <= 1'b0;
    end else if (adv) begin
      k_valid <= s1.valid && s1.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k_last <= s1.last;
      k_col[0] <= (s1.post && s1.x_one) ? cell_q[2] : cell_q[1];
      k_col[1] <= cell_q[2];
      k_col[2] <= s1.post ? new_col : cell_q[2];
    end
  end

  for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_chan
    for (genvar c = 0; c < 3; c++) begin : g_col
      assign k_win[ch][c][0] = k_col[c].top[ch*CHAN_W +: CHAN_W];
      assign k_win[ch][c][1] = k_col[c].mid[ch*CHAN_W +: CHAN_W];
      assign k_win[ch][c][2] = k_col[c].bot[ch*CHAN_W +: CHAN_W];
    end
    gb3x3_kernel u_kernel (.win(k_win[ch]), .result(k_res[ch]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= k_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tlast <= k_last;
      m_tdata <= {color_mode ? k_res[2] : '0, color_mode ? k_res[1] : '0, k_res[0]};
    end
  end

  // While a word is accepted, a middle line store write never lands on the address read in the same cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && s1.valid && s1.wr_middle) |-> (s1.addr != column_count[AW-1:0]))
    else $error("line store write collides with read address");

  // The end of a drain leaves the counters at the start of a frame.
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && drain && column_count >= width_eff && !cfg_restart)
      |=> (column_count == '0 && row_count == '0))
    else $error("frame did not restart after drain");

  // Gray mode results carry nothing in channels one and two.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !color_mode) |-> (m_tdata[PIX_W-1:CHAN_W] == '0))
    else $error("gray result has nonzero upper channels");

  // Used sizes stay within their limits.
  assert property (@(posedge clk) disable iff (rst)
    (width_eff >= WW'(3) && width_eff <= WIDTH_MAX &&
     height_eff >= HW'(3) && height_eff <= HEIGHT_MAX))
    else $error("frame size out of range");

endmodule
